// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define ALM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define ALM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/alm_pkg.sv
// Shared constants and types for the audio level meter.
`timescale 1ns / 1ps

package alm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int LED_COUNT   = 62;

    localparam int LVL_W  = 12;
    localparam int SUM_W  = 28;
    localparam int CNT_W  = 16;
    localparam int BAR_W  = 6;
    localparam int LED_W  = $clog2(LED_COUNT + 1);
    localparam int SQ_W   = 2 * LVL_W;
    localparam int NUM_W  = SQ_W + LED_W;
    localparam int ITER_W = $clog2(LVL_W);

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SAMPLES = 4'd3;

    localparam logic [LVL_W-1:0] RST_DC_OFFSET      = 12'd2048;
    localparam logic [LVL_W-1:0] RST_NOISE_FLOOR    = 12'd50;
    localparam logic [LVL_W-1:0] RST_FULL_SCALE     = 12'd1700;
    localparam logic [CNT_W-1:0] RST_WINDOW_SAMPLES = 16'd1024;

    // Stream widths and output field positions
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 32;
    localparam int OUT_LVL_LO = 0;
    localparam int OUT_PK_LO  = LVL_W;
    localparam int OUT_BAR_LO = 2 * LVL_W;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [LVL_W-1:0] dc_offset;
        logic [LVL_W-1:0] noise_floor;
        logic [LVL_W-1:0] full_scale;
        logic [CNT_W-1:0] window_samples;
    } cfg_t;

    // One finished window handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             clr;
    } win_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// File: sv/alm_front.sv
// Front end: accepts samples and accumulates absolute deviation per window.
`timescale 1ns / 1ps

module alm_front
    import alm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] in_sample,
    input  logic                   in_clear,
    input  fifo_stat_t             q_stat,
    output logic                   q_push,
    output win_t                   q_data
);

    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             clr_reg, clr_next;

    logic             accept;
    logic [LVL_W-1:0] smp;
    logic [LVL_W-1:0] dev;
    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_sat;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] win;
    logic             close;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    // Deviation, saturating sum and count for this sample
    always_comb
    begin
        smp     = LVL_W'(in_sample);
        dev     = (smp >= cfg.dc_offset) ? (smp - cfg.dc_offset) : (cfg.dc_offset - smp);
        sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(dev);
        sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
        cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
        win     = (cfg.window_samples == '0) ? CNT_W'(1) : cfg.window_samples;
        close   = (cnt_inc >= win);
    end

    // Close the window into the queue, or keep accumulating
    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        clr_next = clr_reg;
        q_push   = 1'b0;
        q_data   = '{sum: sum_sat, count: cnt_inc, clr: clr_reg | in_clear};
        if (accept)
        begin
            if (close)
            begin
                q_push   = 1'b1;
                sum_next = '0;
                cnt_next = '0;
                clr_next = 1'b0;
            end
            else
            begin
                sum_next = sum_sat;
                cnt_next = cnt_inc;
                clr_next = clr_reg | in_clear;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            clr_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
        end
    end

endmodule

// File: sv/alm_fifo.sv
// Short queue of finished windows between front and back.
`timescale 1ns / 1ps

module alm_fifo
    import alm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  win_t       push_data,
    input  logic       pop,
    output win_t       pop_data,
    output fifo_stat_t stat
);

    win_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_reg, wr_next;
    logic [FIFO_AW-1:0] rd_reg, rd_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (cnt_reg == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem_reg[rd_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

// File: sv/alm_back.sv
// Back end: divides each window, tracks the peak and maps the level to a bar.
`timescale 1ns / 1ps

module alm_back
    import alm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  fifo_stat_t       q_stat,
    input  win_t             q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [LVL_W-1:0] out_level,
    output logic [LVL_W-1:0] out_peak,
    output logic             out_new_peak,
    output logic [BAR_W-1:0] out_bar
);

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV  = 3'd1;
    localparam logic [2:0] B_SQR  = 3'd2;
    localparam logic [2:0] B_MUL1 = 3'd3;
    localparam logic [2:0] B_MUL2 = 3'd4;
    localparam logic [2:0] B_BDIV = 3'd5;
    localparam logic [2:0] B_DONE = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [LVL_W-1:0]  qd_reg, qd_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic              clr_reg, clr_next;
    logic [LVL_W-1:0]  peak_reg, peak_next;
    logic              fresh_reg, fresh_next;
    logic              zero_reg, zero_next;
    logic [LVL_W-1:0]  d_reg, d_next;
    logic [LVL_W-1:0]  span_reg, span_next;
    logic [SQ_W-1:0]   dsq_reg, dsq_next;
    logic [SQ_W-1:0]   ssq_reg, ssq_next;
    logic [SQ_W-1:0]   brem_reg, brem_next;
    logic [LED_W-1:0]  bqd_reg, bqd_next;
    logic              ov_reg, ov_next;
    logic [LVL_W-1:0]  olvl_reg, olvl_next;
    logic [LVL_W-1:0]  opk_reg, opk_next;
    logic              ofr_reg, ofr_next;
    logic [BAR_W-1:0]  obar_reg, obar_next;

    logic [CNT_W:0]    trial;
    logic [SQ_W:0]     btrial;
    logic [LVL_W-1:0]  base;
    logic [LVL_W-1:0]  diff;
    logic [NUM_W-1:0]  num;
    logic [LED_W-1:0]  bclamp;

    assign out_valid    = ov_reg;
    assign out_level    = olvl_reg;
    assign out_peak     = opk_reg;
    assign out_new_peak = ofr_reg;
    assign out_bar      = obar_reg;

    always_comb
    begin
        trial  = {rem_reg, qd_reg[LVL_W-1]};
        btrial = {brem_reg, bqd_reg[LED_W-1]};
        base   = clr_reg ? '0 : peak_reg;
        diff   = qd_reg - cfg.noise_floor;
        num    = NUM_W'(dsq_reg) * NUM_W'(LED_COUNT);
        bclamp = (bqd_reg > LED_W'(LED_COUNT)) ? LED_W'(LED_COUNT) : bqd_reg;
    end

    // Sequencer over divide, peak, squares and bar divide
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        rem_next   = rem_reg;
        qd_next    = qd_reg;
        den_next   = den_reg;
        clr_next   = clr_reg;
        peak_next  = peak_reg;
        fresh_next = fresh_reg;
        zero_next  = zero_reg;
        d_next     = d_reg;
        span_next  = span_reg;
        dsq_next   = dsq_reg;
        ssq_next   = ssq_reg;
        brem_next  = brem_reg;
        bqd_next   = bqd_reg;
        olvl_next  = olvl_reg;
        opk_next   = opk_reg;
        ofr_next   = ofr_reg;
        obar_next  = obar_reg;
        ov_next    = (ov_reg && out_ready) ? 1'b0 : ov_reg;
        q_pop      = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    // Quotient fits in LVL_W bits, so the upper sum bits start below count
                    q_pop      = 1'b1;
                    rem_next   = q_data.sum[SUM_W-1:LVL_W];
                    qd_next    = q_data.sum[LVL_W-1:0];
                    den_next   = q_data.count;
                    clr_next   = q_data.clr;
                    iter_next  = '0;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                // One restoring quotient bit per cycle
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = CNT_W'(trial - {1'b0, den_reg});
                    qd_next  = {qd_reg[LVL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    qd_next  = {qd_reg[LVL_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(LVL_W - 1))
                begin
                    state_next = B_SQR;
                end
            end
            B_SQR:
            begin
                // Update peak, clamp the distance above the floor
                fresh_next = (qd_reg > base);
                peak_next  = (qd_reg > base) ? qd_reg : base;
                zero_next  = (qd_reg <= cfg.noise_floor) || (cfg.full_scale <= cfg.noise_floor);
                span_next  = cfg.full_scale - cfg.noise_floor;
                d_next     = (diff > span_next) ? span_next : diff;
                state_next = B_MUL1;
            end
            B_MUL1:
            begin
                dsq_next   = d_reg * d_reg;
                ssq_next   = span_reg * span_reg;
                state_next = B_MUL2;
            end
            B_MUL2:
            begin
                // Ratio is at most LED_COUNT, so the upper product bits start below span^2
                brem_next  = num[NUM_W-1:LED_W];
                bqd_next   = num[LED_W-1:0];
                iter_next  = '0;
                state_next = B_BDIV;
            end
            B_BDIV:
            begin
                if (btrial >= {1'b0, ssq_reg})
                begin
                    brem_next = SQ_W'(btrial - {1'b0, ssq_reg});
                    bqd_next  = {bqd_reg[LED_W-2:0], 1'b1};
                end
                else
                begin
                    brem_next = btrial[SQ_W-1:0];
                    bqd_next  = {bqd_reg[LED_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(LED_W - 1))
                begin
                    state_next = B_DONE;
                end
            end
            B_DONE:
            begin
                // Load the output register once it is free
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    olvl_next  = qd_reg;
                    opk_next   = peak_reg;
                    ofr_next   = fresh_reg;
                    obar_next  = zero_reg ? '0 : BAR_W'(bclamp);
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            iter_reg  <= '0;
            peak_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            peak_reg  <= peak_next;
            ov_reg    <= ov_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        qd_reg    <= qd_next;
        den_reg   <= den_next;
        clr_reg   <= clr_next;
        fresh_reg <= fresh_next;
        zero_reg  <= zero_next;
        d_reg     <= d_next;
        span_reg  <= span_next;
        dsq_reg   <= dsq_next;
        ssq_reg   <= ssq_next;
        brem_reg  <= brem_next;
        bqd_reg   <= bqd_next;
        olvl_reg  <= olvl_next;
        opk_reg   <= opk_next;
        ofr_reg   <= ofr_next;
        obar_reg  <= obar_next;
    end

endmodule

// File: sv/audio_level_meter_with_bar_top.sv
// Top level of the audio level meter with quadratic bar output.
//
//  channel  direction  handshake            payload
//  s_*      in         s_tvalid/s_tready    tdata: sample; tuser: clear_peak
//  m_*      out        m_tvalid/m_tready    tdata: level, peak, bar_leds; tuser: new_peak
//  cfg_*    in         cfg_we               cfg_index, cfg_data
//
//  The front end takes one sample per cycle while the window queue has room.
//  A closing window passes through the back end in order: the queue pop, 12 level divide
//  steps, peak and clamp, two multiply stages, 6 bar divide steps and the output load.
//  The two-entry window queue and the output register let each side stall alone.
//  Reset is asynchronous; no clearing pass follows it.
`timescale 1ns / 1ps

module audio_level_meter_with_bar_top
    import alm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample
    input  logic [0:0]            s_tuser,   // [0] clear_peak
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [11:0] level, [23:12] peak, [29:24] bar_leds
    output logic [0:0]            m_tuser,   // [0] new_peak
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg_reg, cfg_next;
    fifo_stat_t       q_stat;
    logic             q_push;
    logic             q_pop;
    win_t             q_in;
    win_t             q_out;
    logic [LVL_W-1:0] level;
    logic [LVL_W-1:0] peak;
    logic             new_peak;
    logic [BAR_W-1:0] bar;

    // Decode configuration writes; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_DC_OFFSET:      cfg_next.dc_offset      = cfg_data[LVL_W-1:0];
                REG_NOISE_FLOOR:    cfg_next.noise_floor    = cfg_data[LVL_W-1:0];
                REG_FULL_SCALE:     cfg_next.full_scale     = cfg_data[LVL_W-1:0];
                REG_WINDOW_SAMPLES: cfg_next.window_samples = cfg_data[CNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{dc_offset:      RST_DC_OFFSET,
                         noise_floor:    RST_NOISE_FLOOR,
                         full_scale:     RST_FULL_SCALE,
                         window_samples: RST_WINDOW_SAMPLES};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    alm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .in_clear  (s_tuser[0]),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    alm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    alm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_stat       (q_stat),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_level    (level),
        .out_peak     (peak),
        .out_new_peak (new_peak),
        .out_bar      (bar)
    );

    // Pack the result fields
    assign m_tdata = {(M_TDATA_W - OUT_BAR_LO - BAR_W)'(0), bar, peak, level};
    assign m_tuser = new_peak;

endmodule

// File: sv/alm_checker.sv
// Port-level checks for the audio level meter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module alm_checker
    import alm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic [0:0]            m_tuser
);

    logic [LVL_W-1:0] lvl;
    logic [LVL_W-1:0] pk;
    logic [BAR_W-1:0] bar;

    assign lvl = m_tdata[OUT_LVL_LO +: LVL_W];
    assign pk  = m_tdata[OUT_PK_LO +: LVL_W];
    assign bar = m_tdata[OUT_BAR_LO +: BAR_W];

    `ALM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `ALM_ASSERT(a_peak_ge_level, m_tvalid |-> pk >= lvl, "peak below level")
    `ALM_ASSERT(a_new_peak_eq, m_tvalid && m_tuser[0] |-> pk == lvl, "new peak differs from level")
    `ALM_ASSERT(a_bar_range, m_tvalid |-> bar <= BAR_W'(LED_COUNT), "bar beyond element count")
    `ALM_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_tvalid, "result valid in reset")

endmodule

bind audio_level_meter_with_bar_top alm_checker u_alm_checker (.*);
